// ----- hdl/wov_pkg.sv -----
`timescale 1ns / 1ps

package wov_pkg;

    // Fixed-point format: fraction bits of every Q value
    localparam int FRAC_BITS = 24;

    // Field widths
    localparam int COUNT_W = 32;
    localparam int IVAL_W  = 32;
    localparam int DPC_W   = 32;
    localparam int OUT_W   = 64;

    // |delta| * distance_per_count is below 2^63
    localparam int MAG_W = COUNT_W + DPC_W - 1;

    // Divider: dividend is the magnitude shifted left by FRAC_BITS
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    // distance_per_count after reset
    localparam logic [DPC_W-1:0] DPC_RESET = DPC_W'(5147);

    localparam logic [OUT_W-1:0] SIGN_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] SIGN_MAX = {1'b0, {(OUT_W-1){1'b1}}};

    // Divider result returned to the sequencer
    typedef struct packed {
        logic [OUT_W-1:0] quot;  // low 64 quotient bits
        logic             ovf;   // quotient reached 2^64
    } div_result_t;

endpackage

// ----- hdl/wheel_odometer_velocity.sv -----
`timescale 1ns / 1ps

// Wheel odometer: step distance, speed and running total from encoder samples.
// Input beat (s_ channel): absolute encoder count and the sample interval.
// Output beat (m_ channel): step distance, speed, running total, saturation flag.
// Config channel (cfg_): writes distance_per_count; a write also clears the
// running total and primed flag; the next beat records its count, with zero step and speed.
// Sequence: accept, a multiply state, an accumulate state that starts the restoring
// divider, the divider steps (63 magnitude bits plus 24 fraction bits, one quotient
// bit per cycle), a done step, then the output load. The next input beat is taken
// after the output load at the earliest. A priming beat goes from accept straight to
// the output load, and a zero interval skips the divider. One item is in flight at a
// time; s_tready and cfg_ready are high only while the sequencer is idle, and a
// pending config write holds s_tready low.
// The result sits in an output register; a new input beat is taken while it
// waits, but the next result is held back until m_tready takes the previous one.
// Reset (aresetn low, synchronous) sets distance_per_count to 5147, clears
// the previous count, primed flag and total, and drops m_tvalid.
module wheel_odometer_velocity (
    input  logic          aclk,
    input  logic          aresetn,
    // input channel
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // [31:0] encoder_count, [63:32] interval
    // result channel
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [191:0]  m_tdata,   // [63:0] step_distance, [127:64] speed,
                                     // [191:128] total_distance
    output logic [0:0]    m_tuser,   // [0] saturated
    // configuration
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data   // distance_per_count
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam int OW = wov_pkg::OUT_W;

    state_t                          state_reg;
    logic [wov_pkg::DPC_W-1:0]       dpc_reg;
    logic [wov_pkg::COUNT_W-1:0]     prev_reg;
    logic                            primed_reg;
    logic [OW-1:0]                   total_reg;
    logic [wov_pkg::IVAL_W-1:0]      iv_reg;
    logic [wov_pkg::COUNT_W-1:0]     absd_reg;
    logic                            neg_reg;
    logic [wov_pkg::MAG_W-1:0]       mag_reg;
    logic [OW-1:0]                   dist_reg;
    logic [OW-1:0]                   speed_reg;
    logic [OW-1:0]                   res_total_reg;
    logic                            sat_reg;
    logic                            m_tvalid_reg;
    logic [191:0]                    m_tdata_reg;
    logic [0:0]                      m_tuser_reg;

    logic [wov_pkg::COUNT_W-1:0]     in_count;
    logic [wov_pkg::IVAL_W-1:0]      in_ival;
    logic [wov_pkg::COUNT_W-1:0]     delta;
    logic [wov_pkg::COUNT_W-1:0]     absd_next;
    logic [2*wov_pkg::DPC_W-1:0]     product;
    logic [OW-1:0]                   mag_ext;
    logic [OW-1:0]                   dist_next;
    logic [OW-1:0]                   sum;
    logic                            total_ovf;
    logic [OW-1:0]                   lim;
    logic                            speed_sat;
    logic [OW-1:0]                   q_sel;
    logic                            s_accept;
    logic                            cfg_accept;
    logic                            div_start;
    logic                            div_done;
    logic                            out_load;
    wov_pkg::div_result_t            div_res;

    assign in_count   = s_tdata[31:0];
    assign in_ival    = s_tdata[63:32];
    assign s_tready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign div_start  = (state_reg == ST_ADD) && (iv_reg != '0);
    assign out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // Count difference and magnitude
    always_comb begin
        delta     = in_count - prev_reg;
        absd_next = delta[wov_pkg::COUNT_W-1] ? (wov_pkg::COUNT_W'(0) - delta) : delta;
        product   = absd_reg * dpc_reg;
    end

    // Signed distance and saturating accumulate
    always_comb begin
        mag_ext   = OW'(mag_reg);
        dist_next = neg_reg ? (OW'(0) - mag_ext) : mag_ext;
        sum       = total_reg + dist_next;
        total_ovf = !(total_reg[OW-1] ^ dist_next[OW-1]) && (sum[OW-1] ^ dist_next[OW-1]);
    end

    // Speed saturation
    always_comb begin
        lim       = neg_reg ? wov_pkg::SIGN_MIN : wov_pkg::SIGN_MAX;
        speed_sat = div_res.ovf || (div_res.quot > lim);
        q_sel     = speed_sat ? lim : div_res.quot;
    end

    wov_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (iv_reg),
        .done     (div_done),
        .result   (div_res)
    );

    // Sequencer, state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dpc_reg      <= wov_pkg::DPC_RESET;
            prev_reg     <= '0;
            primed_reg   <= 1'b0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // result valid: set on load, cleared when taken
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_accept) begin
                        dpc_reg    <= cfg_data;
                        prev_reg   <= '0;
                        primed_reg <= 1'b0;
                        total_reg  <= '0;
                    end else if (s_accept) begin
                        prev_reg <= in_count;
                        iv_reg   <= in_ival;
                        if (!primed_reg) begin
                            primed_reg    <= 1'b1;
                            dist_reg      <= '0;
                            speed_reg     <= '0;
                            res_total_reg <= total_reg;
                            sat_reg       <= 1'b0;
                            state_reg     <= ST_OUT;
                        end else begin
                            absd_reg  <= absd_next;
                            neg_reg   <= delta[wov_pkg::COUNT_W-1];
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    mag_reg   <= product[wov_pkg::MAG_W-1:0];
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    dist_reg <= dist_next;
                    if (total_ovf) begin
                        total_reg     <= neg_reg ? wov_pkg::SIGN_MIN : wov_pkg::SIGN_MAX;
                        res_total_reg <= neg_reg ? wov_pkg::SIGN_MIN : wov_pkg::SIGN_MAX;
                    end else begin
                        total_reg     <= sum;
                        res_total_reg <= sum;
                    end
                    sat_reg <= total_ovf;
                    if (iv_reg != '0) begin
                        state_reg <= ST_DIV;
                    end else begin
                        speed_reg <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        speed_reg <= neg_reg ? (OW'(0) - q_sel) : q_sel;
                        sat_reg   <= sat_reg | speed_sat;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_tdata_reg  <= {res_total_reg, speed_reg, dist_reg};
                        m_tuser_reg  <= sat_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- hdl/wov_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// Divides {dividend, FRAC_BITS zeros} by a nonzero divisor.
module wov_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [wov_pkg::MAG_W-1:0]           dividend,
    input  logic [wov_pkg::IVAL_W-1:0]          divisor,
    output logic                                done,
    output wov_pkg::div_result_t                result
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [wov_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [wov_pkg::DVD_W-1:0]        dvd_reg;
    logic [wov_pkg::IVAL_W-1:0]       div_reg;
    logic [wov_pkg::IVAL_W-1:0]       rem_reg;
    logic [wov_pkg::OUT_W-1:0]        quot_reg;
    logic                             ovf_reg;

    logic [wov_pkg::IVAL_W:0]         trial;
    logic [wov_pkg::IVAL_W:0]         diff;
    logic                             ge;
    logic [wov_pkg::IVAL_W-1:0]       rem_next;

    // Trial subtract of the partial remainder
    always_comb begin
        trial    = {rem_reg, dvd_reg[wov_pkg::DVD_W-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = (trial >= {1'b0, div_reg});
        rem_next = ge ? diff[wov_pkg::IVAL_W-1:0] : trial[wov_pkg::IVAL_W-1:0];
    end

    // Step counter and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= wov_pkg::DIV_CNT_W'(wov_pkg::DVD_W);
                dvd_reg  <= {dividend, {wov_pkg::FRAC_BITS{1'b0}}};
                div_reg  <= divisor;
                rem_reg  <= '0;
                quot_reg <= '0;
                ovf_reg  <= 1'b0;
            end else if (busy_reg) begin
                dvd_reg  <= {dvd_reg[wov_pkg::DVD_W-2:0], 1'b0};
                rem_reg  <= rem_next;
                quot_reg <= {quot_reg[wov_pkg::OUT_W-2:0], ge};
                // a set bit pushed out of the top means quotient >= 2^64
                ovf_reg  <= ovf_reg | quot_reg[wov_pkg::OUT_W-1];
                cnt_reg  <= cnt_reg - wov_pkg::DIV_CNT_W'(1);
                if (cnt_reg == wov_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done        = done_reg;
    assign result.quot = quot_reg;
    assign result.ovf  = ovf_reg;

endmodule

// ----- hdl/wov_checker.sv -----
`timescale 1ns / 1ps

module wov_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [191:0]  m_tdata,
    input logic [0:0]    m_tuser,
    input logic          cfg_valid,
    input logic          cfg_ready
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // An accepted item keeps the block busy in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !cfg_ready)
        else $error("input taken again right after accept");

    // A new result is posted only as the sequencer returns to idle
    a_post_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> cfg_ready)
        else $error("result posted while sequencer busy");

    // Input readiness is config readiness with no config write pending
    a_ready_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_ready && !cfg_valid) == s_tready)
        else $error("config and input readiness differ");

    // Reset drops the result valid
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind wheel_odometer_velocity wov_checker u_wov_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
